// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the window stability detector.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define WSD_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);
// Expression must never be true outside reset.
`define WSD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error(msg);
`else
`define WSD_ASSERT(lbl, clk, rst_n, prop, msg)
`define WSD_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

// ----- rtl/wsd_pkg.sv -----
// Shared types and constants of the window stability detector.
package wsd_pkg;

	localparam int SAMPLE_W         = 16;
	localparam int PCT_W            = 7;
	localparam int CFG_IDX_W        = 3;
	localparam int WINDOW_DEPTH_DEF = 16;

	// span * pct, at most 65535 * 127
	localparam int PROD_W = SAMPLE_W + PCT_W;

	// Exact divide by 100 for any PROD_W-bit value: (p * RECIP) >> RECIP_SH
	localparam int RECIP_W  = 24;
	localparam int RECIP_SH = 30;
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(10737419);
	localparam int QMUL_W   = PROD_W + RECIP_W;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_LEVEL   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ZERO_CEILING = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FULL_FLOOR   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BAND_PCT     = 3'd4;

	// Configuration reset values
	localparam logic [SAMPLE_W-1:0] ZERO_LEVEL_RST   = 16'd0;
	localparam logic [SAMPLE_W-1:0] FULL_LEVEL_RST   = 16'hFFFF;
	localparam logic [PCT_W-1:0]    ZERO_CEILING_RST = 7'd10;
	localparam logic [PCT_W-1:0]    FULL_FLOOR_RST   = 7'd50;
	localparam logic [PCT_W-1:0]    BAND_PCT_RST     = 7'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_THR_MUL,
		S_THR_DIV,
		S_ZONE,
		S_BAND_MUL,
		S_BAND_DIV,
		S_BOUNDS,
		S_WALK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic mul_en;
		logic div_en;
	} pct_ctl_t;

	typedef struct packed {
		logic shift;
		logic load;
	} cell_ctl_t;

endpackage

// ----- rtl/window_stability_detector.sv -----
// Top level of the window stability detector: control, registers and cell chain.
// Sequence: restart beat straight to done; other beats pass threshold multiply,
//   threshold divide and zone test, and an in-zone beat with a full window adds
//   band multiply, band divide, bounds and a walk rotating the cell chain one entry
//   per cycle past one band checker. No new beat is taken until the last is done.
// Reset: arst_n clears control, fill state and out_valid and loads config defaults.
`include "assert_macros.svh"

module window_stability_detector #(
	parameter int WINDOW_DEPTH = wsd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsd_pkg::SAMPLE_W-1:0]   cfg_data,
	// input channel
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wsd_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           zero_phase,
	input  logic                           restart,
	// result channel
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           settled
);

	localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int SUM_W = wsd_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int CMP_W = SUM_W + 2;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
	localparam logic signed [CMP_W-1:0] DEPTH_S = CMP_W'(WINDOW_DEPTH);
	localparam logic signed [CMP_W-1:0] ONE_S   = CMP_W'(1);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [wsd_pkg::SAMPLE_W-1:0] zero_level_q;
	logic [wsd_pkg::SAMPLE_W-1:0] full_level_q;
	logic [wsd_pkg::PCT_W-1:0]    zero_ceiling_q;
	logic [wsd_pkg::PCT_W-1:0]    full_floor_q;
	logic [wsd_pkg::PCT_W-1:0]    band_pct_q;

	// drop writes to indexes beyond the register list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_level_q   <= wsd_pkg::ZERO_LEVEL_RST;
			full_level_q   <= wsd_pkg::FULL_LEVEL_RST;
			zero_ceiling_q <= wsd_pkg::ZERO_CEILING_RST;
			full_floor_q   <= wsd_pkg::FULL_FLOOR_RST;
			band_pct_q     <= wsd_pkg::BAND_PCT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wsd_pkg::REG_ZERO_LEVEL:   zero_level_q   <= cfg_data;
				wsd_pkg::REG_FULL_LEVEL:   full_level_q   <= cfg_data;
				wsd_pkg::REG_ZERO_CEILING: zero_ceiling_q <= cfg_data[wsd_pkg::PCT_W-1:0];
				wsd_pkg::REG_FULL_FLOOR:   full_floor_q   <= cfg_data[wsd_pkg::PCT_W-1:0];
				wsd_pkg::REG_BAND_PCT:     band_pct_q     <= cfg_data[wsd_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	// span wraps mod 2^16; a zero span counts as one
	logic [wsd_pkg::SAMPLE_W-1:0] span_raw;
	logic [wsd_pkg::SAMPLE_W-1:0] span;
	assign span_raw = full_level_q - zero_level_q;
	assign span     = (span_raw == '0) ? wsd_pkg::SAMPLE_W'(1) : span_raw;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	wsd_pkg::state_t state_q, state_nxt;

	logic [wsd_pkg::SAMPLE_W-1:0] sample_q;
	logic                         zero_phase_q;
	logic [PTR_W-1:0]             wp_q;
	logic                         full_q;
	logic [SUM_W-1:0]             sum_q;
	logic [PTR_W-1:0]             cnt_q;
	logic                         ok_q;
	logic                         res_q;
	logic signed [CMP_W-1:0]      hi_q;
	logic signed [CMP_W-1:0]      lo_q;
	logic                         out_valid_q;
	logic                         settled_q;

	logic                         out_free;
	logic                         in_zone;
	logic                         new_full;
	logic [wsd_pkg::SAMPLE_W-1:0] thr;
	logic [wsd_pkg::SAMPLE_W-1:0] pct_res;
	logic [wsd_pkg::SAMPLE_W-1:0] last_val;
	logic [SUM_W-1:0]             sum_nxt;
	logic                         band_fail;

	wsd_pkg::pct_ctl_t            pct_ctl;
	logic                         sel_band;
	logic [wsd_pkg::PCT_W-1:0]    pct_in;
	logic                         chain_shift;
	logic                         chain_insert;
	logic                         out_load;

	assign out_free = !out_valid_q || !out_stall;

	// zone test against zero_level + span * pct / 100, wrapped to 16 bits
	assign thr     = zero_level_q + pct_res;
	assign in_zone = zero_phase_q ? (sample_q < thr) : (sample_q > thr);

	// evict the oldest entry, held by the last cell, once the ring is full
	assign sum_nxt  = sum_q - (full_q ? SUM_W'(last_val) : SUM_W'(0)) + SUM_W'(sample_q);
	assign new_full = full_q || (wp_q == PTR_LAST);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			wsd_pkg::S_IDLE: begin
				if (in_valid) begin
					state_nxt = restart ? wsd_pkg::S_DONE : wsd_pkg::S_THR_MUL;
				end
			end
			wsd_pkg::S_THR_MUL:  state_nxt = wsd_pkg::S_THR_DIV;
			wsd_pkg::S_THR_DIV:  state_nxt = wsd_pkg::S_ZONE;
			wsd_pkg::S_ZONE: begin
				state_nxt = (in_zone && new_full) ? wsd_pkg::S_BAND_MUL : wsd_pkg::S_DONE;
			end
			wsd_pkg::S_BAND_MUL: state_nxt = wsd_pkg::S_BAND_DIV;
			wsd_pkg::S_BAND_DIV: state_nxt = wsd_pkg::S_BOUNDS;
			wsd_pkg::S_BOUNDS:   state_nxt = wsd_pkg::S_WALK;
			wsd_pkg::S_WALK: begin
				if (cnt_q == PTR_LAST) begin
					state_nxt = wsd_pkg::S_DONE;
				end
			end
			wsd_pkg::S_DONE: begin
				if (out_free) begin
					state_nxt = wsd_pkg::S_IDLE;
				end
			end
			default: state_nxt = wsd_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_stall       = (state_q != wsd_pkg::S_IDLE);
		pct_ctl.mul_en = (state_q == wsd_pkg::S_THR_MUL) || (state_q == wsd_pkg::S_BAND_MUL);
		pct_ctl.div_en = (state_q == wsd_pkg::S_THR_DIV) || (state_q == wsd_pkg::S_BAND_DIV);
		sel_band       = (state_q == wsd_pkg::S_BAND_MUL);
		chain_insert   = (state_q == wsd_pkg::S_ZONE);
		chain_shift    = ((state_q == wsd_pkg::S_ZONE) && in_zone)
		                 || (state_q == wsd_pkg::S_WALK);
		out_load       = (state_q == wsd_pkg::S_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wsd_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// hold the accepted beat for the rest of its processing
	always_ff @(posedge clk) begin
		if (state_q == wsd_pkg::S_IDLE && in_valid) begin
			sample_q     <= sample;
			zero_phase_q <= zero_phase;
		end
	end

	// ---------------------------------------------------------------
	// Window bookkeeping and band walk
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			full_q <= 1'b0;
			sum_q  <= '0;
			cnt_q  <= '0;
			ok_q   <= 1'b0;
			res_q  <= 1'b0;
		end else begin
			unique case (state_q)
				wsd_pkg::S_IDLE: begin
					res_q <= 1'b0;
					if (in_valid && restart) begin
						wp_q   <= '0;
						full_q <= 1'b0;
						sum_q  <= '0;
					end
				end
				wsd_pkg::S_ZONE: begin
					if (in_zone) begin
						sum_q  <= sum_nxt;
						full_q <= new_full;
						wp_q   <= (wp_q == PTR_LAST) ? '0 : wp_q + PTR_W'(1);
					end
				end
				wsd_pkg::S_BOUNDS: begin
					cnt_q <= '0;
					ok_q  <= 1'b1;
				end
				wsd_pkg::S_WALK: begin
					// check the last cell while the chain rotates by one
					ok_q  <= ok_q && !band_fail;
					cnt_q <= (cnt_q == PTR_LAST) ? '0 : cnt_q + PTR_W'(1);
					if (cnt_q == PTR_LAST) begin
						res_q <= ok_q && !band_fail;
					end
				end
				default: ;
			endcase
		end
	end

	// scaled bounds: entry*D > sum + band*D fails high,
	// entry*D <= sum - (band+1)*D fails low
	logic signed [CMP_W-1:0] sum_s;
	logic signed [CMP_W-1:0] band_s;
	assign sum_s  = signed'(CMP_W'(sum_q));
	assign band_s = signed'(CMP_W'(pct_res));

	always_ff @(posedge clk) begin
		if (state_q == wsd_pkg::S_BOUNDS) begin
			hi_q <= sum_s + band_s * DEPTH_S;
			lo_q <= sum_s - (band_s + ONE_S) * DEPTH_S;
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			settled_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				settled_q   <= res_q;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign settled   = settled_q;

	// ---------------------------------------------------------------
	// Shared percent unit
	// ---------------------------------------------------------------
	assign pct_in = sel_band ? band_pct_q : (zero_phase_q ? zero_ceiling_q : full_floor_q);

	wsd_pct_unit u_pct (
		.clk    (clk),
		.ctl    (pct_ctl),
		.span   (span),
		.pct    (pct_in),
		.result (pct_res)
	);

	// ---------------------------------------------------------------
	// Cell chain: cell 0 takes the new sample or the wrapped last entry
	// ---------------------------------------------------------------
	logic [wsd_pkg::SAMPLE_W-1:0] cell_val [WINDOW_DEPTH];

	assign last_val = cell_val[WINDOW_DEPTH-1];

	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		wsd_pkg::cell_ctl_t           cell_ctl;
		logic [wsd_pkg::SAMPLE_W-1:0] prev_val;
		if (i == 0) begin : g_head
			assign cell_ctl = '{shift: chain_shift, load: chain_insert};
			assign prev_val = cell_val[WINDOW_DEPTH-1];
		end else begin : g_body
			assign cell_ctl = '{shift: chain_shift, load: 1'b0};
			assign prev_val = cell_val[i-1];
		end
		wsd_cell u_cell (
			.clk       (clk),
			.ctl       (cell_ctl),
			.load_data (sample_q),
			.prev_data (prev_val),
			.value     (cell_val[i])
		);
	end

	wsd_band_check #(
		.WINDOW_DEPTH (WINDOW_DEPTH),
		.CMP_W        (CMP_W)
	) u_check (
		.value (last_val),
		.hi    (hi_q),
		.lo    (lo_q),
		.fail  (band_fail)
	);

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`WSD_ASSERT(a_accept_leaves_idle, clk, arst_n,
		(in_valid && !in_stall) |=> (state_q != wsd_pkg::S_IDLE),
		"accepted beat did not start processing")
	`WSD_ASSERT(a_restart_clears, clk, arst_n,
		(in_valid && !in_stall && restart) |=> (!full_q && wp_q == '0 && sum_q == '0),
		"restart beat did not clear the window")
	`WSD_ASSERT(a_done_loads_output, clk, arst_n,
		(state_q == wsd_pkg::S_DONE && out_free) |=> out_valid_q,
		"finished beat not presented on the result channel")
	`WSD_ASSERT_NEVER(a_walk_count_idle, clk, arst_n,
		(state_q != wsd_pkg::S_WALK) && (cnt_q != '0),
		"walk counter busy outside the band walk")

endmodule

// ----- rtl/wsd_cell.sv -----
// One window entry of the rotating cell chain.
module wsd_cell (
	input  logic                          clk,
	input  wsd_pkg::cell_ctl_t            ctl,
	input  logic [wsd_pkg::SAMPLE_W-1:0]  load_data,
	input  logic [wsd_pkg::SAMPLE_W-1:0]  prev_data,
	output logic [wsd_pkg::SAMPLE_W-1:0]  value
);

	logic [wsd_pkg::SAMPLE_W-1:0] value_q;

	// take a new sample or the neighbor's entry on each shift
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			value_q <= ctl.load ? load_data : prev_data;
		end
	end

	assign value = value_q;

endmodule

// ----- rtl/wsd_pct_unit.sv -----
// Two-stage span * pct / 100 unit, truncated to 16 bits.
module wsd_pct_unit (
	input  logic                          clk,
	input  wsd_pkg::pct_ctl_t             ctl,
	input  logic [wsd_pkg::SAMPLE_W-1:0]  span,
	input  logic [wsd_pkg::PCT_W-1:0]     pct,
	output logic [wsd_pkg::SAMPLE_W-1:0]  result
);

	logic [wsd_pkg::PROD_W-1:0]   prod_q;
	logic [wsd_pkg::SAMPLE_W-1:0] result_q;
	logic [wsd_pkg::QMUL_W-1:0]   qmul;

	assign qmul = wsd_pkg::QMUL_W'(prod_q) * wsd_pkg::QMUL_W'(wsd_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= wsd_pkg::PROD_W'(span) * wsd_pkg::PROD_W'(pct);
		end
		if (ctl.div_en) begin
			result_q <= qmul[wsd_pkg::RECIP_SH +: wsd_pkg::SAMPLE_W];
		end
	end

	assign result = result_q;

endmodule

// ----- rtl/wsd_band_check.sv -----
// Band test of one entry against the scaled window bounds.
module wsd_band_check #(
	parameter int WINDOW_DEPTH = wsd_pkg::WINDOW_DEPTH_DEF,
	parameter int CMP_W        = wsd_pkg::SAMPLE_W + $clog2(WINDOW_DEPTH) + 2
) (
	input  logic [wsd_pkg::SAMPLE_W-1:0]  value,
	input  logic signed [CMP_W-1:0]       hi,
	input  logic signed [CMP_W-1:0]       lo,
	output logic                          fail
);

	localparam logic signed [CMP_W-1:0] DEPTH_S = CMP_W'(WINDOW_DEPTH);

	logic signed [CMP_W-1:0] value_s;
	logic signed [CMP_W-1:0] scaled;

	// entry * depth against sum-based bounds stands for entry against avg +/- band
	assign value_s = signed'(CMP_W'(value));
	assign scaled  = value_s * DEPTH_S;
	assign fail    = (scaled > hi) || (scaled <= lo);

endmodule

// ----- sim/window_stability_checker.sv -----
// Scoreboard for the window stability detector: predicts settled per beat and checks results.
`timescale 1ns / 1ps

module window_stability_checker #(
	parameter int WINDOW_DEPTH = wsd_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [wsd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wsd_pkg::SAMPLE_W-1:0]   cfg_data,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic [wsd_pkg::SAMPLE_W-1:0]   sample,
	input  logic                           zero_phase,
	input  logic                           restart,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic                           settled,
	output int unsigned                    mismatches,
	output int unsigned                    outstanding
);

	localparam int unsigned PCT_SCALE = 100;
	localparam int unsigned REPORT_MAX = 10;

	// register copies
	logic [wsd_pkg::SAMPLE_W-1:0] zero_lvl;
	logic [wsd_pkg::SAMPLE_W-1:0] full_lvl;
	logic [wsd_pkg::PCT_W-1:0]    ceil_pct;
	logic [wsd_pkg::PCT_W-1:0]    floor_pct;
	logic [wsd_pkg::PCT_W-1:0]    band_pct;

	// sample ring with running sum
	logic [wsd_pkg::SAMPLE_W-1:0] ring [WINDOW_DEPTH];
	int unsigned                  fill_pos;
	int unsigned                  ring_sum;
	logic                         ring_full;

	logic        settled_q [$];
	logic        want;
	int unsigned errs;

	function automatic logic [wsd_pkg::SAMPLE_W-1:0] share_of_span(
			input logic [wsd_pkg::SAMPLE_W-1:0] span, input logic [wsd_pkg::PCT_W-1:0] pct);
		return wsd_pkg::SAMPLE_W'((32'(span) * 32'(pct)) / PCT_SCALE);
	endfunction

	// Advance the ring by one beat and return the expected settled flag.
	function automatic logic predict_settled(input logic [wsd_pkg::SAMPLE_W-1:0] s,
			input logic zp, input logic rs);
		logic [wsd_pkg::SAMPLE_W-1:0] span;
		logic [wsd_pkg::SAMPLE_W-1:0] thr;
		logic [wsd_pkg::SAMPLE_W-1:0] band;
		int unsigned                  avg;
		logic                         hit;
		logic                         ok;
		int                           i;
		if (rs) begin
			fill_pos  = 0;
			ring_sum  = 0;
			ring_full = 1'b0;
			return 1'b0;
		end
		span = full_lvl - zero_lvl;
		if (span == '0)
			span = wsd_pkg::SAMPLE_W'(1);
		thr = zero_lvl + share_of_span(span, zp ? ceil_pct : floor_pct);
		hit = zp ? (s < thr) : (s > thr);
		if (!hit)
			return 1'b0;
		if (ring_full)
			ring_sum -= ring[fill_pos];
		ring[fill_pos] = s;
		ring_sum += s;
		fill_pos = (fill_pos + 1) % WINDOW_DEPTH;
		if (fill_pos == 0)
			ring_full = 1'b1;
		if (!ring_full)
			return 1'b0;
		avg  = ring_sum / WINDOW_DEPTH;
		band = share_of_span(span, band_pct);
		ok   = 1'b1;
		for (i = 0; i < WINDOW_DEPTH; i++) begin
			if (int'(ring[i]) > int'(avg) + int'(band) || int'(ring[i]) < int'(avg) - int'(band))
				ok = 1'b0;
		end
		return ok;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_lvl  = wsd_pkg::ZERO_LEVEL_RST;
			full_lvl  = wsd_pkg::FULL_LEVEL_RST;
			ceil_pct  = wsd_pkg::ZERO_CEILING_RST;
			floor_pct = wsd_pkg::FULL_FLOOR_RST;
			band_pct  = wsd_pkg::BAND_PCT_RST;
			fill_pos  = 0;
			ring_sum  = 0;
			ring_full = 1'b0;
			errs      = 0;
			settled_q.delete();
			mismatches  <= 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					wsd_pkg::REG_ZERO_LEVEL:   zero_lvl  = cfg_data;
					wsd_pkg::REG_FULL_LEVEL:   full_lvl  = cfg_data;
					wsd_pkg::REG_ZERO_CEILING: ceil_pct  = cfg_data[wsd_pkg::PCT_W-1:0];
					wsd_pkg::REG_FULL_FLOOR:   floor_pct = cfg_data[wsd_pkg::PCT_W-1:0];
					wsd_pkg::REG_BAND_PCT:     band_pct  = cfg_data[wsd_pkg::PCT_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				if (settled_q.size() == 0) begin
					if (errs < REPORT_MAX)
						$display("%0t: result beat with nothing expected, settled=%0b",
							$realtime, settled);
					errs++;
				end else begin
					want = settled_q.pop_front();
					if (settled !== want) begin
						if (errs < REPORT_MAX)
							$display("%0t: settled mismatch, expected %0b, got %0b",
								$realtime, want, settled);
						errs++;
					end
				end
			end
			if (in_valid && !in_stall)
				settled_q.push_back(predict_settled(sample, zero_phase, restart));
			mismatches  <= errs;
			outstanding <= settled_q.size();
		end
	end

endmodule

// ----- sim/window_stability_detector_tb.sv -----
// Testbench top of the window stability detector: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps

module window_stability_detector_tb;

	localparam int          WINDOW_DEPTH = wsd_pkg::WINDOW_DEPTH_DEF;
	localparam int unsigned TOTAL_BEATS  = 1850;
	localparam int unsigned PHASE_BEATS  = 150;
	localparam int unsigned STALL_LIMIT  = 4000;
	localparam int unsigned DRAIN_CYCLES = WINDOW_DEPTH + 16;
	localparam int unsigned PCT_SCALE    = 100;
	localparam int unsigned MAX_WAIT     = 15;
	// first index past the register map; writes there must change nothing
	localparam logic [wsd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 3'd5;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [wsd_pkg::SAMPLE_W-1:0]  cfg_data;
	logic                          in_valid;
	logic                          in_stall;
	logic [wsd_pkg::SAMPLE_W-1:0]  sample;
	logic                          zero_phase;
	logic                          restart;
	logic                          out_valid;
	logic                          out_stall;
	logic                          settled;
	int unsigned                   mismatches;
	int unsigned                   outstanding;

	// stimulus-side view of the registers, used only to aim samples at the zones and band
	logic [wsd_pkg::SAMPLE_W-1:0]  cfg_zero;
	logic [wsd_pkg::SAMPLE_W-1:0]  cfg_full;
	logic [wsd_pkg::PCT_W-1:0]     cfg_ceil;
	logic [wsd_pkg::PCT_W-1:0]     cfg_floor;
	logic [wsd_pkg::PCT_W-1:0]     cfg_band;
	logic [wsd_pkg::SAMPLE_W-1:0]  ceil_thr;
	logic [wsd_pkg::SAMPLE_W-1:0]  floor_thr;
	logic [wsd_pkg::SAMPLE_W-1:0]  band_w;

	logic                          quiet;
	int unsigned                   beats_sent;
	int unsigned                   idle_cycles;
	int                            k;

	window_stability_detector #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sample     (sample),
		.zero_phase (zero_phase),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.settled    (settled)
	);

	window_stability_checker #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.sample      (sample),
		.zero_phase  (zero_phase),
		.restart     (restart),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.settled     (settled),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Quiet stretches force back-to-back beats; otherwise draw a random wait up to MAX_WAIT.
	function automatic int unsigned idle_draw();
		return quiet ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	// Offset above zero_level for a percent of the span, as the block truncates it.
	function automatic logic [wsd_pkg::SAMPLE_W-1:0] level_at(
			input logic [wsd_pkg::PCT_W-1:0] pct);
		logic [wsd_pkg::SAMPLE_W-1:0] span;
		span = cfg_full - cfg_zero;
		if (span == '0)
			span = wsd_pkg::SAMPLE_W'(1);
		return wsd_pkg::SAMPLE_W'((32'(span) * 32'(pct)) / PCT_SCALE);
	endfunction

	// Record the register values and the zone edges they give.
	task automatic track_regs(input logic [wsd_pkg::SAMPLE_W-1:0] zl,
			input logic [wsd_pkg::SAMPLE_W-1:0] fl, input logic [wsd_pkg::PCT_W-1:0] cp,
			input logic [wsd_pkg::PCT_W-1:0] fp, input logic [wsd_pkg::PCT_W-1:0] bp);
		cfg_zero  = zl;
		cfg_full  = fl;
		cfg_ceil  = cp;
		cfg_floor = fp;
		cfg_band  = bp;
		ceil_thr  = cfg_zero + level_at(cfg_ceil);
		floor_thr = cfg_zero + level_at(cfg_floor);
		band_w    = level_at(cfg_band);
	endtask

	// Write all five registers back to back, then poke an unmapped index.
	// Keep write enable high across the burst and drop it once at the end.
	task automatic program_regs(input logic [wsd_pkg::SAMPLE_W-1:0] zl,
			input logic [wsd_pkg::SAMPLE_W-1:0] fl, input logic [wsd_pkg::PCT_W-1:0] cp,
			input logic [wsd_pkg::PCT_W-1:0] fp, input logic [wsd_pkg::PCT_W-1:0] bp);
		logic [wsd_pkg::SAMPLE_W-wsd_pkg::PCT_W-1:0] junk;
		// junk in the upper bits of the percent writes must be masked off
		junk = $urandom_range(0, 1) ? (wsd_pkg::SAMPLE_W-wsd_pkg::PCT_W)'($urandom) : '0;
		cfg_we    <= 1'b1;
		cfg_index <= wsd_pkg::REG_ZERO_LEVEL;
		cfg_data  <= zl;
		@(posedge clk);
		cfg_index <= wsd_pkg::REG_FULL_LEVEL;
		cfg_data  <= fl;
		@(posedge clk);
		cfg_index <= wsd_pkg::REG_ZERO_CEILING;
		cfg_data  <= {junk, cp};
		@(posedge clk);
		cfg_index <= wsd_pkg::REG_FULL_FLOOR;
		cfg_data  <= {junk, fp};
		@(posedge clk);
		cfg_index <= wsd_pkg::REG_BAND_PCT;
		cfg_data  <= {junk, bp};
		@(posedge clk);
		cfg_index <= REG_UNMAPPED_FIRST + wsd_pkg::CFG_IDX_W'($urandom_range(0, 2));
		cfg_data  <= wsd_pkg::SAMPLE_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		track_regs(zl, fl, cp, fp, bp);
	endtask

	// Offer one input beat and hold it until accepted.
	// Keep valid high when the next beat follows with no gap.
	task automatic send_beat(input logic [wsd_pkg::SAMPLE_W-1:0] s, input logic zp,
			input logic rs);
		int unsigned gap;
		gap = idle_draw();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		sample     <= s;
		zero_phase <= zp;
		restart    <= rs;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		beats_sent++;
	endtask

	// Feed a run of in-zone samples clustered around one level so the window can
	// settle; noise_pct of the beats are replaced by raw noise to break the run.
	task automatic settle_run(input logic zp, input int unsigned len, input int unsigned noise_pct);
		int lo;
		int hi;
		int mid;
		int jit;
		int v;
		if (zp) begin
			lo = 0;
			hi = int'(ceil_thr) - 1;
		end else begin
			lo = int'(floor_thr) + 1;
			hi = (1 << wsd_pkg::SAMPLE_W) - 1;
		end
		// empty zone: every sample lands outside it anyway
		if (hi < lo) begin
			lo = 0;
			hi = (1 << wsd_pkg::SAMPLE_W) - 1;
		end
		mid = int'($urandom_range(lo, hi));
		// mostly tight runs that settle, sometimes spread wider than the band
		if ($urandom_range(0, 3) != 0)
			jit = int'(band_w) / 2;
		else
			jit = int'(band_w) * 2 + int'($urandom_range(0, 64));
		repeat (len) begin
			if ($urandom_range(1, 100) <= noise_pct) begin
				send_beat(wsd_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
					$urandom_range(0, 15) == 0);
			end else begin
				v = mid - jit + int'($urandom_range(0, 2 * jit));
				if (v < lo)
					v = lo;
				if (v > hi)
					v = hi;
				send_beat(wsd_pkg::SAMPLE_W'(v), zp, 1'b0);
			end
		end
	endtask

	// Drop valid and hold until every expected result beat has come back.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	// One phase of random traffic under a fixed register setting.
	task automatic run_phase(input int unsigned beats);
		int unsigned stop;
		stop = beats_sent + beats;
		while (beats_sent < stop) begin
			quiet = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// clean window first half of the time
					if ($urandom_range(0, 1))
						send_beat(wsd_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
							1'b1);
					settle_run(1'($urandom_range(0, 1)), $urandom_range(WINDOW_DEPTH,
						WINDOW_DEPTH + 8), 0);
				end
				6, 7: settle_run(1'($urandom_range(0, 1)),
					$urandom_range(3, WINDOW_DEPTH + 4), 25);
				default: begin
					repeat ($urandom_range(1, 6))
						send_beat(wsd_pkg::SAMPLE_W'($urandom), 1'($urandom_range(0, 1)),
							$urandom_range(0, 3) == 0);
				end
			endcase
		end
		drain();
	endtask

	// Result side: stall for a drawn number of cycles, then take one beat.
	initial begin
		int unsigned hold;
		forever begin
			hold = idle_draw();
			out_stall <= (hold != 0);
			if (hold != 0) begin
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall))
				@(posedge clk);
		end
	end

	// Watchdog: end the run when no beat or register write moves for too long.
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n     <= 1'b0;
		cfg_we     <= 1'b0;
		cfg_index  <= wsd_pkg::REG_ZERO_LEVEL;
		cfg_data   <= '0;
		in_valid   <= 1'b0;
		sample     <= '0;
		zero_phase <= 1'b0;
		restart    <= 1'b0;
		beats_sent  = 0;
		quiet       = 1'b0;
		track_regs(wsd_pkg::ZERO_LEVEL_RST, wsd_pkg::FULL_LEVEL_RST,
			wsd_pkg::ZERO_CEILING_RST, wsd_pkg::FULL_FLOOR_RST, wsd_pkg::BAND_PCT_RST);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset settings: zero zone ends below 6553,
		// full zone starts above 32767, band is 1310.
		send_beat('1, 1'b1, 1'b1);                  // restart ignores sample and phase
		send_beat('0, 1'b1, 1'b0);                  // lowest reading, in zero zone
		send_beat(ceil_thr - wsd_pkg::SAMPLE_W'(1), 1'b1, 1'b0);  // just under the ceiling
		send_beat(ceil_thr, 1'b1, 1'b0);            // on the ceiling: out of zone
		send_beat('1, 1'b1, 1'b0);                  // full scale at rest: out of zone
		send_beat(floor_thr, 1'b0, 1'b0);           // on the floor: out of zone
		send_beat(floor_thr + wsd_pkg::SAMPLE_W'(1), 1'b0, 1'b0); // just over the floor
		send_beat('1, 1'b0, 1'b0);                  // full scale, in full zone
		send_beat('0, 1'b0, 1'b0);                  // zero reading under full pull
		send_beat('0, 1'b0, 1'b1);                  // clear the partial window
		// fill the ring with a tight cluster: the last beat of it settles
		for (k = 0; k < WINDOW_DEPTH; k++)
			send_beat(wsd_pkg::SAMPLE_W'(40000 + 100 * k), 1'b0, 1'b0);
		send_beat(wsd_pkg::SAMPLE_W'(50000), 1'b0, 1'b0);    // outlier breaks the band
		drain();
		run_phase(PHASE_BEATS / 2);

		// Settings with special meaning before random ones: equal levels give a
		// span of one, a full level below zero wraps the span, percents above 100
		// wrap the thresholds, and an inverted extreme wraps the floor to the bottom.
		program_regs(16'd1234, 16'd1234, 7'd100, 7'd0, 7'd0);
		run_phase(PHASE_BEATS);
		program_regs(16'd60000, 16'd1000, 7'd127, 7'd127, 7'd127);
		run_phase(PHASE_BEATS);
		program_regs('1, '0, 7'd0, 7'd100, 7'd100);
		run_phase(PHASE_BEATS);
		program_regs('0, '1, 7'd101, 7'd0, 7'd1);
		run_phase(PHASE_BEATS);

		while (beats_sent < TOTAL_BEATS) begin
			cfg_zero = wsd_pkg::SAMPLE_W'($urandom);
			case ($urandom_range(0, 5))
				0:       cfg_full = cfg_zero;
				1:       cfg_full = cfg_zero - wsd_pkg::SAMPLE_W'($urandom_range(1, 5000));
				default: cfg_full = wsd_pkg::SAMPLE_W'($urandom);
			endcase
			program_regs(cfg_zero, cfg_full,
				($urandom_range(0, 3) == 0) ? wsd_pkg::PCT_W'($urandom_range(0, 127))
					: wsd_pkg::PCT_W'($urandom_range(0, 100)),
				($urandom_range(0, 3) == 0) ? wsd_pkg::PCT_W'($urandom_range(0, 127))
					: wsd_pkg::PCT_W'($urandom_range(0, 100)),
				($urandom_range(0, 3) == 0) ? wsd_pkg::PCT_W'($urandom_range(0, 127))
					: wsd_pkg::PCT_W'($urandom_range(0, 20)));
			run_phase(PHASE_BEATS);
		end

		// Let any stray result beat show up before the verdict.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
